/* rtl/thrq_pkg.sv */
// ----------------------------------------------------------------------------
// thrq_pkg
// Shared types, codes and arithmetic helpers of the terrain height ray query.
// ----------------------------------------------------------------------------
package thrq_pkg;

	// operation codes of a request
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	// register indexes on the configuration port
	localparam logic [1:0] REG_START   = 2'd0;
	localparam logic [1:0] REG_MAXDIST = 2'd1;
	localparam logic [1:0] REG_DETTHR  = 2'd2;
	localparam int unsigned ADDR_W = 4;

	// datapath widths
	localparam int unsigned EDGE_W = 33;   // vertex differences
	localparam int unsigned PROD_W = 66;   // edge products, det, u, v, cross terms
	localparam int unsigned TSUM_W = 100;  // scaled distance numerator
	localparam int unsigned REM_W  = 96;   // divider remainder
	localparam int unsigned DIV_W  = 65;   // divider operand, |det|
	localparam int unsigned QUO_W  = 31;   // unsigned Q15.16 distance

	// reset values of the registers
	localparam logic signed [31:0] START_RST = 32'sd65536000;
	localparam logic [30:0] MAXDIST_RST      = 31'd131072000;
	localparam logic [30:0] DETTHR_RST       = 31'd1;

	typedef logic signed [31:0] coord_t;

	typedef struct packed {
		coord_t x0; coord_t y0; coord_t z0;
		coord_t x1; coord_t y1; coord_t z1;
		coord_t x2; coord_t y2; coord_t z2;
	} tri_t;

	typedef struct packed {
		coord_t min_x;
		coord_t max_x;
		coord_t min_z;
		coord_t max_z;
	} bnd_t;

	typedef struct packed {
		logic signed [31:0] start_height;
		logic [30:0]        max_dist;
		logic [30:0]        det_thr;
	} cfg_t;

	// pipeline slot: a live triangle, and the end-of-walk marker
	typedef struct packed {
		logic vld;
		logic last;
	} tag_t;

	function automatic logic signed [EDGE_W-1:0] sext33(input logic signed [31:0] v);
		sext33 = {v[31], v};
	endfunction

	function automatic logic signed [PROD_W-1:0] mul33(input logic signed [EDGE_W-1:0] a,
	                                                   input logic signed [EDGE_W-1:0] b);
		mul33 = PROD_W'(a) * PROD_W'(b);
	endfunction

	// signed by unsigned partial product
	function automatic logic signed [PROD_W-1:0] mulsu(input logic signed [EDGE_W-1:0] a,
	                                                   input logic [EDGE_W-1:0] b);
		mulsu = PROD_W'(a) * $signed({33'd0, b});
	endfunction

endpackage

/* rtl/thrq_ifs.sv */
// ----------------------------------------------------------------------------
// thrq request and response channels
// Valid/ready channels carrying requests in and query results out.
// ----------------------------------------------------------------------------
interface thrq_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic signed [31:0] vx0;
	logic signed [31:0] vy0;
	logic signed [31:0] vz0;
	logic signed [31:0] vx1;
	logic signed [31:0] vy1;
	logic signed [31:0] vz1;
	logic signed [31:0] vx2;
	logic signed [31:0] vy2;
	logic signed [31:0] vz2;
	logic signed [31:0] query_x;
	logic signed [31:0] query_z;

	modport source (output valid, op, vx0, vy0, vz0, vx1, vy1, vz1, vx2, vy2, vz2,
		query_x, query_z, input ready);
	modport sink (input valid, op, vx0, vy0, vz0, vx1, vy1, vz1, vx2, vy2, vz2,
		query_x, query_z, output ready);
endinterface

interface thrq_rsp_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic signed [31:0] height;
	logic               table_overflow;

	modport source (output valid, hit, height, table_overflow, input ready);
	modport sink (input valid, hit, height, table_overflow, output ready);
endinterface

/* rtl/thrq_div_cell.sv */
// ----------------------------------------------------------------------------
// thrq_div_cell
// One restoring division step: tries |det| at the top weight, shifts left.
// ----------------------------------------------------------------------------
module thrq_div_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  thrq_pkg::tag_t              tag_in,
	input  logic [thrq_pkg::REM_W-1:0]  rem_in,
	input  logic [thrq_pkg::DIV_W-1:0]  div_in,
	input  logic [thrq_pkg::QUO_W-1:0]  quo_in,
	output thrq_pkg::tag_t              tag_out,
	output logic [thrq_pkg::REM_W-1:0]  rem_out,
	output logic [thrq_pkg::DIV_W-1:0]  div_out,
	output logic [thrq_pkg::QUO_W-1:0]  quo_out
);
	import thrq_pkg::*;

	logic [REM_W-1:0] step;
	logic             take;
	logic [REM_W-1:0] left;
	tag_t             tag_q;
	logic [REM_W-1:0] rem_q;
	logic [DIV_W-1:0] div_q;
	logic [QUO_W-1:0] quo_q;

	// compare and subtract the divisor at the top quotient weight
	always_comb begin
		step = REM_W'({div_in, {(QUO_W-1){1'b0}}});
		take = (step <= rem_in);
		left = take ? (rem_in - step) : rem_in;
	end

	// slot tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else begin
			tag_q <= tag_in;
		end
	end

	// hand the partial result to the next cell
	always_ff @(posedge clk) begin
		rem_q <= {left[REM_W-2:0], 1'b0};
		div_q <= div_in;
		quo_q <= {quo_in[QUO_W-2:0], take};
	end

	assign tag_out = tag_q;
	assign rem_out = rem_q;
	assign div_out = div_q;
	assign quo_out = quo_q;

endmodule

/* rtl/thrq_isect.sv */
// ----------------------------------------------------------------------------
// thrq_isect
// Pipelined downward-ray triangle test with a chain of divider cells for t.
// ----------------------------------------------------------------------------
module thrq_isect (
	input  logic                       clk,
	input  logic                       arst_n,
	input  thrq_pkg::cfg_t             cfg,
	input  thrq_pkg::coord_t           qx,
	input  thrq_pkg::coord_t           qz,
	input  thrq_pkg::tag_t             tag_s1,
	input  thrq_pkg::tri_t             tri_s1,
	input  thrq_pkg::bnd_t             bnd_s1,
	output thrq_pkg::tag_t             res_tag,
	output logic [thrq_pkg::QUO_W-1:0] res_dist
);
	import thrq_pkg::*;

	// stage a: edges, ray offset, box test
	logic signed [EDGE_W-1:0] e1x_a, e1y_a, e1z_a, e2x_a, e2y_a, e2z_a, sx_a, sy_a, sz_a;
	logic                     box_a;
	tag_t                     tag_s2;
	logic signed [EDGE_W-1:0] e1x_s2, e1y_s2, e1z_s2, e2x_s2, e2y_s2, e2z_s2;
	logic signed [EDGE_W-1:0] sx_s2, sy_s2, sz_s2;

	// stage b: products
	tag_t                     tag_s3;
	logic signed [PROD_W-1:0] p0_s3, p1_s3, p2_s3, p3_s3, p4_s3, p5_s3, p6_s3, p7_s3;
	logic signed [PROD_W-1:0] p8_s3, p9_s3;
	logic signed [EDGE_W-1:0] e2x_s3, e2y_s3, e2z_s3;

	// stage c: det, u, v and the cross product
	tag_t                     tag_s4;
	logic signed [PROD_W-1:0] det_s4, u_s4, v_s4, cx_s4, cy_s4, cz_s4;
	logic signed [EDGE_W-1:0] e2x_s4, e2y_s4, e2z_s4;

	// stage d: sign fold and dot product partials
	tag_t                     tag_s5;
	logic                     neg_s5;
	logic signed [PROD_W-1:0] ad_s5, au_s5, av_s5;
	logic signed [PROD_W-1:0] lx_s5, hx_s5, ly_s5, hy_s5, lz_s5, hz_s5;

	// stage e: range checks, dot terms, distance bound partials
	logic                     ok_e;
	tag_t                     tag_s6;
	logic                     ok_s6, neg_s6;
	logic signed [TSUM_W-1:0] tx_s6, ty_s6, tz_s6;
	logic [63:0]              mlo_s6;
	logic [62:0]              mhi_s6;
	logic [DIV_W-1:0]         ad_s6;

	// stage f: sums
	tag_t                     tag_s7;
	logic                     ok_s7, neg_s7;
	logic signed [TSUM_W-1:0] tsum_s7;
	logic [REM_W-1:0]         md_s7;
	logic [DIV_W-1:0]         ad_s7;

	// stage g: sign of t numerator
	tag_t                     tag_s8;
	logic                     ok_s8;
	logic signed [TSUM_W-1:0] tf_s8;
	logic [REM_W-1:0]         md_s8;
	logic [DIV_W-1:0]         ad_s8;

	// stage h: final accept, divider entry
	tag_t                     tag_s9;
	logic [REM_W-1:0]         rem_s9;
	logic [DIV_W-1:0]         div_s9;

	// divider chain
	tag_t             cell_tag [0:QUO_W];
	logic [REM_W-1:0] cell_rem [0:QUO_W];
	logic [DIV_W-1:0] cell_div [0:QUO_W];
	logic [QUO_W-1:0] cell_quo [0:QUO_W];

	// edges and ray origin relative to the first vertex
	always_comb begin
		e1x_a = sext33(tri_s1.x1) - sext33(tri_s1.x0);
		e1y_a = sext33(tri_s1.y1) - sext33(tri_s1.y0);
		e1z_a = sext33(tri_s1.z1) - sext33(tri_s1.z0);
		e2x_a = sext33(tri_s1.x2) - sext33(tri_s1.x0);
		e2y_a = sext33(tri_s1.y2) - sext33(tri_s1.y0);
		e2z_a = sext33(tri_s1.z2) - sext33(tri_s1.z0);
		sx_a  = sext33(qx) - sext33(tri_s1.x0);
		sy_a  = sext33(cfg.start_height) - sext33(tri_s1.y0);
		sz_a  = sext33(qz) - sext33(tri_s1.z0);
		box_a = (qx >= bnd_s1.min_x) && (qx <= bnd_s1.max_x) &&
		        (qz >= bnd_s1.min_z) && (qz <= bnd_s1.max_z);
	end

	// final range checks on the folded values
	always_comb begin
		ok_e = (ad_s5 != '0) && (ad_s5 >= $signed({35'd0, cfg.det_thr})) &&
		       !au_s5[PROD_W-1] && (au_s5 <= ad_s5) && !av_s5[PROD_W-1] &&
		       ((67'(au_s5) + 67'(av_s5)) <= 67'(ad_s5));
	end

	// slot tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
			tag_s7 <= '0;
			tag_s8 <= '0;
			tag_s9 <= '0;
		end else begin
			tag_s2 <= '{vld: tag_s1.vld && box_a, last: tag_s1.last};
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
			tag_s7 <= tag_s6;
			tag_s8 <= tag_s7;
			tag_s9 <= '{vld: tag_s8.vld && ok_s8 && !tf_s8[TSUM_W-1] &&
			            (tf_s8 <= $signed({4'd0, md_s8})), last: tag_s8.last};
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		e1x_s2 <= e1x_a; e1y_s2 <= e1y_a; e1z_s2 <= e1z_a;
		e2x_s2 <= e2x_a; e2y_s2 <= e2y_a; e2z_s2 <= e2z_a;
		sx_s2  <= sx_a;  sy_s2  <= sy_a;  sz_s2  <= sz_a;

		p0_s3 <= mul33(e1z_s2, e2x_s2);
		p1_s3 <= mul33(e1x_s2, e2z_s2);
		p2_s3 <= mul33(sz_s2, e2x_s2);
		p3_s3 <= mul33(sx_s2, e2z_s2);
		p4_s3 <= mul33(sx_s2, e1z_s2);
		p5_s3 <= mul33(sz_s2, e1x_s2);
		p6_s3 <= mul33(sy_s2, e1z_s2);
		p7_s3 <= mul33(sz_s2, e1y_s2);
		p8_s3 <= mul33(sx_s2, e1y_s2);
		p9_s3 <= mul33(sy_s2, e1x_s2);
		e2x_s3 <= e2x_s2; e2y_s3 <= e2y_s2; e2z_s3 <= e2z_s2;

		det_s4 <= p0_s3 - p1_s3;
		u_s4   <= p2_s3 - p3_s3;
		v_s4   <= p4_s3 - p5_s3;
		cx_s4  <= p6_s3 - p7_s3;
		cy_s4  <= p5_s3 - p4_s3;
		cz_s4  <= p8_s3 - p9_s3;
		e2x_s4 <= e2x_s3; e2y_s4 <= e2y_s3; e2z_s4 <= e2z_s3;

		neg_s5 <= det_s4[PROD_W-1];
		ad_s5  <= det_s4[PROD_W-1] ? -det_s4 : det_s4;
		au_s5  <= det_s4[PROD_W-1] ? -u_s4 : u_s4;
		av_s5  <= det_s4[PROD_W-1] ? -v_s4 : v_s4;
		lx_s5  <= mulsu(e2x_s4, cx_s4[32:0]);
		hx_s5  <= mul33(e2x_s4, $signed(cx_s4[65:33]));
		ly_s5  <= mulsu(e2y_s4, cy_s4[32:0]);
		hy_s5  <= mul33(e2y_s4, $signed(cy_s4[65:33]));
		lz_s5  <= mulsu(e2z_s4, cz_s4[32:0]);
		hz_s5  <= mul33(e2z_s4, $signed(cz_s4[65:33]));

		ok_s6  <= ok_e;
		neg_s6 <= neg_s5;
		tx_s6  <= (TSUM_W'(hx_s5) <<< 33) + TSUM_W'(lx_s5);
		ty_s6  <= (TSUM_W'(hy_s5) <<< 33) + TSUM_W'(ly_s5);
		tz_s6  <= (TSUM_W'(hz_s5) <<< 33) + TSUM_W'(lz_s5);
		mlo_s6 <= 64'(cfg.max_dist) * 64'(ad_s5[32:0]);
		mhi_s6 <= 63'(cfg.max_dist) * 63'(ad_s5[64:33]);
		ad_s6  <= ad_s5[DIV_W-1:0];

		ok_s7   <= ok_s6;
		neg_s7  <= neg_s6;
		tsum_s7 <= tx_s6 + ty_s6 + tz_s6;
		md_s7   <= (REM_W'(mhi_s6) << 33) + REM_W'(mlo_s6);
		ad_s7   <= ad_s6;

		ok_s8 <= ok_s7;
		tf_s8 <= neg_s7 ? -tsum_s7 : tsum_s7;
		md_s8 <= md_s7;
		ad_s8 <= ad_s7;

		rem_s9 <= tf_s8[REM_W-1:0];
		div_s9 <= ad_s8;
	end

	// chain of division cells, one quotient bit each
	assign cell_tag[0] = tag_s9;
	assign cell_rem[0] = rem_s9;
	assign cell_div[0] = div_s9;
	assign cell_quo[0] = '0;

	for (genvar gi = 0; gi < QUO_W; gi++) begin : g_cell
		thrq_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tag_in  (cell_tag[gi]),
			.rem_in  (cell_rem[gi]),
			.div_in  (cell_div[gi]),
			.quo_in  (cell_quo[gi]),
			.tag_out (cell_tag[gi+1]),
			.rem_out (cell_rem[gi+1]),
			.div_out (cell_div[gi+1]),
			.quo_out (cell_quo[gi+1])
		);
	end

	assign res_tag  = cell_tag[QUO_W];
	assign res_dist = cell_quo[QUO_W];

endmodule

/* rtl/thrq_apb_regs.sv */
// ----------------------------------------------------------------------------
// thrq_apb_regs
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module thrq_apb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [thrq_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output thrq_pkg::cfg_t              cfg
);
	import thrq_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_height <= START_RST;
			cfg_q.max_dist     <= MAXDIST_RST;
			cfg_q.det_thr      <= DETTHR_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_START:   cfg_q.start_height <= $signed(pwdata);
				REG_MAXDIST: cfg_q.max_dist     <= pwdata[30:0];
				REG_DETTHR:  cfg_q.det_thr      <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (paddr[3:2])
			REG_START:   prdata = cfg_q.start_height;
			REG_MAXDIST: prdata = {1'b0, cfg_q.max_dist};
			REG_DETTHR:  prdata = {1'b0, cfg_q.det_thr};
			default:     prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

/* rtl/terrain_height_ray_query_core.sv */
// ----------------------------------------------------------------------------
// terrain_height_ray_query_core
// Triangle table with downward-ray height queries over Q16.16 coordinates.
// ----------------------------------------------------------------------------
// Requests arrive on req (valid/ready): op clear, load triangle or height
// query. Clear and load leave the block ready for the next request; a load
// into a full table is dropped and sets the sticky overflow flag. A query
// returns one result on rsp (hit, height, table_overflow); other ops return
// nothing. A query walks the stored triangles one per cycle out of the table
// memory into the intersection pipeline, then waits for the last slot to
// leave the 31-cell divider chain. req.ready is low from the query until
// its result is registered. The finished result sits in an output
// register, so new requests are taken while it waits; a stalled rsp only
// holds back the end of the next query. The user must write configuration
// over the APB port at byte addresses 0, 4 and 8 only while the block is
// idle; the block itself does not enforce this. After reset the table is
// empty, the flag is clear and the registers hold their defaults.
// ----------------------------------------------------------------------------
module terrain_height_ray_query_core #(
	parameter int unsigned MAX_TRIANGLES = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	thrq_req_if.sink                    req,
	thrq_rsp_if.source                  rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [thrq_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import thrq_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_TRIANGLES + 1);
	localparam int unsigned IDX_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_HOLD  = 2'd3;

	cfg_t             cfg;
	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic             ovf_q;
	logic             acc;
	logic             full;
	logic             ld_ok;
	logic             out_free;
	coord_t           qx_q, qz_q;
	tri_t             tri_in;
	bnd_t             bnd_in;
	tri_t             tri_mem [MAX_TRIANGLES];
	bnd_t             bnd_mem [MAX_TRIANGLES];
	tri_t             tri_s1;
	bnd_t             bnd_s1;
	tag_t             tag_s1;
	tag_t             res_tag;
	logic [QUO_W-1:0] res_dist;
	logic             hit_q;
	logic [QUO_W-1:0] best_q;
	logic signed [32:0] h_diff;
	logic signed [31:0] h_fin;
	logic             out_vld_q;
	logic             out_hit_q;
	logic signed [31:0] out_height_q;
	logic             out_ovf_q;

	// configuration port
	thrq_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign full      = (cnt_q >= CNT_W'(MAX_TRIANGLES));
	assign ld_ok     = acc && (req.op == OP_LOAD) && !full;
	assign out_free  = !out_vld_q || rsp.ready;

	// incoming triangle and its x/z box
	always_comb begin
		tri_in = '{req.vx0, req.vy0, req.vz0, req.vx1, req.vy1, req.vz1,
		           req.vx2, req.vy2, req.vz2};
		bnd_in.min_x = req.vx0;
		bnd_in.max_x = req.vx0;
		bnd_in.min_z = req.vz0;
		bnd_in.max_z = req.vz0;
		if (req.vx1 < bnd_in.min_x) bnd_in.min_x = req.vx1;
		if (req.vx2 < bnd_in.min_x) bnd_in.min_x = req.vx2;
		if (req.vx1 > bnd_in.max_x) bnd_in.max_x = req.vx1;
		if (req.vx2 > bnd_in.max_x) bnd_in.max_x = req.vx2;
		if (req.vz1 < bnd_in.min_z) bnd_in.min_z = req.vz1;
		if (req.vz2 < bnd_in.min_z) bnd_in.min_z = req.vz2;
		if (req.vz1 > bnd_in.max_z) bnd_in.max_z = req.vz1;
		if (req.vz2 > bnd_in.max_z) bnd_in.max_z = req.vz2;
	end

	// table memories, one row per triangle
	always_ff @(posedge clk) begin
		if (ld_ok) begin
			tri_mem[cnt_q[IDX_W-1:0]] <= tri_in;
			bnd_mem[cnt_q[IDX_W-1:0]] <= bnd_in;
		end
		tri_s1 <= tri_mem[idx_q[IDX_W-1:0]];
		bnd_s1 <= bnd_mem[idx_q[IDX_W-1:0]];
	end

	// request handling and walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			idx_q   <= '0;
			tag_s1  <= '0;
		end else begin
			tag_s1 <= '{vld: (state_q == ST_WALK) && (idx_q != cnt_q),
			            last: (state_q == ST_WALK) && (idx_q == cnt_q)};
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (req.op)
							OP_CLEAR: begin
								cnt_q <= '0;
								ovf_q <= 1'b0;
							end
							OP_LOAD: begin
								if (full) ovf_q <= 1'b1;
								else cnt_q <= cnt_q + CNT_W'(1);
							end
							OP_QUERY: begin
								idx_q   <= '0;
								state_q <= ST_WALK;
							end
							default: ;
						endcase
					end
				end
				ST_WALK: begin
					if (idx_q == cnt_q) state_q <= ST_DRAIN;
					else idx_q <= idx_q + CNT_W'(1);
				end
				ST_DRAIN: begin
					if (res_tag.last) state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// query point, held for the walk
	always_ff @(posedge clk) begin
		if (acc && (req.op == OP_QUERY)) begin
			qx_q <= req.query_x;
			qz_q <= req.query_z;
		end
	end

	// intersection pipeline
	thrq_isect u_isect (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.qx       (qx_q),
		.qz       (qz_q),
		.tag_s1   (tag_s1),
		.tri_s1   (tri_s1),
		.bnd_s1   (bnd_s1),
		.res_tag  (res_tag),
		.res_dist (res_dist)
	);

	// nearest hit, first one wins a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (acc && (req.op == OP_QUERY)) begin
			hit_q <= 1'b0;
		end else if (res_tag.vld) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_tag.vld && (!hit_q || (res_dist < best_q))) best_q <= res_dist;
	end

	// height with saturation at the bottom of the range
	always_comb begin
		h_diff = sext33(cfg.start_height) - $signed({2'b00, best_q});
		if (!hit_q) h_fin = '0;
		else if (h_diff[32] && !h_diff[31]) h_fin = 32'sh8000_0000;
		else h_fin = h_diff[31:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((state_q == ST_HOLD) && out_free) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_HOLD) && out_free) begin
			out_hit_q    <= hit_q;
			out_height_q <= h_fin;
			out_ovf_q    <= ovf_q;
		end
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.hit            = out_hit_q;
	assign rsp.height         = out_height_q;
	assign rsp.table_overflow = out_ovf_q;

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_TRIANGLES))
		else $error("triangle count beyond table size");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (req.op == OP_LOAD) && full) |=> (ovf_q && $stable(cnt_q)))
		else $error("load into full table not dropped");

	a_marker_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_tag.last |-> (state_q == ST_DRAIN))
		else $error("end of walk marker outside drain");

	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (req.op == OP_QUERY)) |=> ((state_q == ST_WALK) && (idx_q == '0) && !hit_q))
		else $error("query did not start a fresh walk");

endmodule

/* tb/sv/tb_terrain_height_ray_query_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_terrain_height_ray_query_core
// Self-checking bench for the downward-ray terrain height query core.
// Drives clear, load and query requests with random idle gaps on both
// channels, models the triangle table and the exact intersection test
// locally, and compares every query result field by field in order.
// ----------------------------------------------------------------------------
module tb_terrain_height_ray_query_core;
	import thrq_pkg::*;

	localparam int TRI_MAX = 1024;
	localparam int ONE     = 65536;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic        hit;
		logic [31:0] height;
		logic        ovf;
	} height_result_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	thrq_req_if req_ch();
	thrq_rsp_if rsp_ch();

	terrain_height_ray_query_core #(.MAX_TRIANGLES(TRI_MAX)) dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// local copy of the triangle table and registers
	tri_t tri_tab [TRI_MAX];
	bnd_t box_tab [TRI_MAX];
	int   tri_cnt;
	logic ovf_flag;
	cfg_t cfg;

	height_result_t pending_heights[$];
	int error_count, checked_count, hit_count, load_count, query_count;
	bit send_burst, rsp_burst;

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// gap length: mostly none or short, a few long
	function automatic int pick_gap(bit burst);
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// height seen by a downward ray at (qx, qz) over the stored triangles
	function automatic height_result_t predict_height(int qx, int qz);
		height_result_t res;
		wide_t e1x, e1y, e1z, e2x, e2y, e2z, sx, sy, sz;
		wide_t det, uu, vv, cx, cy, cz, tt, tq, best, h;
		tri_t tr;
		res.hit = 1'b0;
		best = 0;
		for (int i = 0; i < tri_cnt; i++) begin
			if (qx < box_tab[i].min_x || qx > box_tab[i].max_x ||
			    qz < box_tab[i].min_z || qz > box_tab[i].max_z) continue;
			tr  = tri_tab[i];
			e1x = wide_t'(tr.x1) - wide_t'(tr.x0);
			e1y = wide_t'(tr.y1) - wide_t'(tr.y0);
			e1z = wide_t'(tr.z1) - wide_t'(tr.z0);
			e2x = wide_t'(tr.x2) - wide_t'(tr.x0);
			e2y = wide_t'(tr.y2) - wide_t'(tr.y0);
			e2z = wide_t'(tr.z2) - wide_t'(tr.z0);
			sx  = wide_t'(qx) - wide_t'(tr.x0);
			sy  = wide_t'(cfg.start_height) - wide_t'(tr.y0);
			sz  = wide_t'(qz) - wide_t'(tr.z0);
			det = e1z * e2x - e1x * e2z;
			uu  = sz * e2x - sx * e2z;
			vv  = sx * e1z - sz * e1x;
			cx  = sy * e1z - sz * e1y;
			cy  = sz * e1x - sx * e1z;
			cz  = sx * e1y - sy * e1x;
			tt  = e2x * cx + e2y * cy + e2z * cz;
			if (det < 0) begin
				det = -det; uu = -uu; vv = -vv; tt = -tt;
			end
			if (det == 0 || det < wide_t'({1'b0, cfg.det_thr})) continue;
			if (uu < 0 || uu > det || vv < 0 || uu + vv > det) continue;
			if (tt < 0 || tt > wide_t'({1'b0, cfg.max_dist}) * det) continue;
			tq = tt / det;
			if (!res.hit || tq < best) begin
				best    = tq;
				res.hit = 1'b1;
			end
		end
		h = 0;
		if (res.hit) begin
			h = wide_t'(cfg.start_height) - best;
			if (h < -wide_t'(64'sh80000000)) h = -wide_t'(64'sh80000000);
		end
		res.height = h[31:0];
		res.ovf    = ovf_flag;
		return res;
	endfunction

	// apply one accepted request to the local table
	task automatic apply_request(logic [1:0] op, tri_t tr, int qx, int qz);
		bnd_t b;
		if (op == OP_CLEAR) begin
			tri_cnt  = 0;
			ovf_flag = 1'b0;
		end else if (op == OP_LOAD) begin
			load_count++;
			if (tri_cnt >= TRI_MAX) begin
				ovf_flag = 1'b1;
			end else begin
				b.min_x = tr.x0; b.max_x = tr.x0; b.min_z = tr.z0; b.max_z = tr.z0;
				if (tr.x1 < b.min_x) b.min_x = tr.x1;
				if (tr.x2 < b.min_x) b.min_x = tr.x2;
				if (tr.x1 > b.max_x) b.max_x = tr.x1;
				if (tr.x2 > b.max_x) b.max_x = tr.x2;
				if (tr.z1 < b.min_z) b.min_z = tr.z1;
				if (tr.z2 < b.min_z) b.min_z = tr.z2;
				if (tr.z1 > b.max_z) b.max_z = tr.z1;
				if (tr.z2 > b.max_z) b.max_z = tr.z2;
				tri_tab[tri_cnt] = tr;
				box_tab[tri_cnt] = b;
				tri_cnt++;
			end
		end else if (op == OP_QUERY) begin
			query_count++;
			pending_heights.insert(pending_heights.size(), predict_height(qx, qz));
		end
	endtask

	// send one request; valid stays high across back-to-back requests
	task automatic send_req(logic [1:0] op, tri_t tr, int qx, int qz);
		int gap;
		gap = pick_gap(send_burst);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.op      <= op;
		req_ch.vx0     <= tr.x0; req_ch.vy0 <= tr.y0; req_ch.vz0 <= tr.z0;
		req_ch.vx1     <= tr.x1; req_ch.vy1 <= tr.y1; req_ch.vz1 <= tr.z1;
		req_ch.vx2     <= tr.x2; req_ch.vy2 <= tr.y2; req_ch.vz2 <= tr.z2;
		req_ch.query_x <= qx;
		req_ch.query_z <= qz;
		do @(posedge clk); while (!req_ch.ready);
		apply_request(op, tr, qx, qz);
	endtask

	task automatic send_load(tri_t tr);
		send_req(OP_LOAD, tr, $urandom, $urandom);
	endtask

	task automatic send_query(int qx, int qz);
		tri_t junk;
		junk = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom};
		send_req(OP_QUERY, junk, qx, qz);
	endtask

	task automatic send_clear();
		tri_t junk;
		junk = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom};
		send_req(OP_CLEAR, junk, $urandom, $urandom);
	endtask

	// wait for all results, then let the block settle
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (pending_heights.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// register write over the configuration port, only while idle
	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx) << 2;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_START:   cfg.start_height = val;
			REG_MAXDIST: cfg.max_dist     = val[30:0];
			REG_DETTHR:  cfg.det_thr      = val[30:0];
			default: ;
		endcase
	endtask

	function automatic tri_t make_tri(int x0, int y0, int z0, int x1, int y1, int z1,
	                                  int x2, int y2, int z2);
		tri_t tr;
		tr = {x0, y0, z0, x1, y1, z1, x2, y2, z2};
		return tr;
	endfunction

	// triangle near a center, heights around a base
	function automatic tri_t near_tri(int cx, int cz, int span, int ybase, int yvar);
		tri_t tr;
		tr.x0 = cx + $urandom_range(0, 2 * span) - span;
		tr.x1 = cx + $urandom_range(0, 2 * span) - span;
		tr.x2 = cx + $urandom_range(0, 2 * span) - span;
		tr.z0 = cz + $urandom_range(0, 2 * span) - span;
		tr.z1 = cz + $urandom_range(0, 2 * span) - span;
		tr.z2 = cz + $urandom_range(0, 2 * span) - span;
		tr.y0 = ybase + $urandom_range(0, 2 * yvar) - yvar;
		tr.y1 = ybase + $urandom_range(0, 2 * yvar) - yvar;
		tr.y2 = ybase + $urandom_range(0, 2 * yvar) - yvar;
		return tr;
	endfunction

	function automatic tri_t noise_tri();
		tri_t tr;
		tr = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom};
		return tr;
	endfunction

	// response stall pattern
	initial begin
		int hold;
		hold = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				rsp_ch.ready <= 1'b0;
				hold--;
			end else begin
				rsp_ch.ready <= 1'b1;
				hold = pick_gap(rsp_burst);
			end
		end
	end

	initial begin
		forever begin
			repeat ($urandom_range(200, 800)) @(posedge clk);
			rsp_burst = ($urandom_range(0, 3) == 0);
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		height_result_t exp_r;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_heights.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected result hit=%0b height=%0d ovf=%0b",
						rsp_ch.hit, rsp_ch.height, rsp_ch.table_overflow);
			end else begin
				exp_r = pending_heights.pop_front();
				checked_count++;
				if (exp_r.hit) hit_count++;
				if (rsp_ch.hit !== exp_r.hit || rsp_ch.height !== exp_r.height ||
				    rsp_ch.table_overflow !== exp_r.ovf) begin
					error_count++;
					if (error_count <= 10)
						$display("mismatch on result %0d: exp hit=%0b h=%0d ovf=%0b got hit=%0b h=%0d ovf=%0b",
							checked_count, exp_r.hit, $signed(exp_r.height), exp_r.ovf,
							rsp_ch.hit, rsp_ch.height, rsp_ch.table_overflow);
				end
			end
		end
	end

	// directed: extremes, ties, degenerate triangle, unused op
	task automatic test_directed();
		send_burst = 1'b0;
		send_query(0, 0);
		send_load(make_tri(0, 10 * ONE, 0, 4 * ONE, 10 * ONE, 0, 0, 10 * ONE, 4 * ONE));
		send_query(ONE, ONE);
		send_query(0, 0);
		send_query(4 * ONE, 0);
		send_query(2 * ONE, 2 * ONE);
		send_query(3 * ONE, 3 * ONE);
		send_query(-1, 0);
		// same plane again, on the other half of the square
		send_load(make_tri(4 * ONE, 10 * ONE, 4 * ONE, 0, 10 * ONE, 4 * ONE,
			4 * ONE, 10 * ONE, 0));
		send_load(make_tri(0, 2 * ONE, 0, 8 * ONE, 20 * ONE, 0, 0, 6 * ONE, 8 * ONE));
		send_query(ONE, ONE);
		// collinear in x/z gives a zero determinant
		send_load(make_tri(0, 0, 0, ONE, 5 * ONE, ONE, 2 * ONE, 9 * ONE, 2 * ONE));
		send_query(ONE, ONE);
		send_req(2'd3, noise_tri(), 0, 0);
		send_load(make_tri(32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h80000000,
			32'h80000000, 32'h7fffffff, 32'h7fffffff));
		send_query(32'h80000000, 32'h80000000);
		send_query(32'h7fffffff, 32'h7fffffff);
		send_query(0, 0);
		send_query(32'h7fffffff, 32'h80000000);
		send_clear();
		send_query(ONE, ONE);
	endtask

	// register settings, extremes among them
	task automatic test_config_sweep();
		int starts[4] = '{32'h80000000, 32'h7fffffff, -5 * ONE, 1000 * ONE};
		int dists[4]  = '{0, 32'h7fffffff, 3 * ONE, 2000 * ONE};
		int thrs[4]   = '{0, 32'h7fffffff, 1 << 20, 1};
		send_burst = 1'b1;
		for (int s = 0; s < 4; s++) begin
			reg_write(REG_START, starts[s]);
			reg_write(REG_MAXDIST, dists[s]);
			reg_write(REG_DETTHR, thrs[s]);
			send_clear();
			send_load(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
			send_load(make_tri(0, 32'h80000000, 0, 8 * ONE, 32'h80000000, 0,
				0, 32'h80000000, 8 * ONE));
			send_load(make_tri(0, starts[s], 0, 8 * ONE, starts[s], 0,
				0, starts[s], 8 * ONE));
			send_load(make_tri(0, -2 * ONE, 0, ONE, 3 * ONE, ONE,
				2 * ONE, 7 * ONE, 2 * ONE));
			for (int k = 0; k < 4; k++) begin
				send_load(near_tri(2 * ONE, 2 * ONE, 4 * ONE, -3 * ONE, 2 * ONE));
				send_query($urandom_range(0, 4 * ONE), $urandom_range(0, 4 * ONE));
			end
			send_query(0, 0);
			send_query(ONE, ONE);
		end
		reg_write(REG_START, START_RST);
		reg_write(REG_MAXDIST, MAXDIST_RST);
		reg_write(REG_DETTHR, DETTHR_RST);
		send_burst = 1'b0;
	endtask

	// fill the table, overflow it, then clear
	task automatic test_overflow();
		send_clear();
		send_burst = 1'b1;
		for (int i = 0; i < TRI_MAX; i++)
			send_load(near_tri(0, 0, 16 * ONE, $urandom_range(0, 50 * ONE), ONE));
		send_query(ONE, -ONE);
		send_load(near_tri(0, 0, 4 * ONE, 0, ONE));
		send_load(near_tri(0, 0, 4 * ONE, 0, ONE));
		send_burst = 1'b0;
		send_query(0, 0);
		send_query(-2 * ONE, 3 * ONE);
		send_clear();
		send_query(0, 0);
	endtask

	// random well-formed clusters with some noise and odd requests
	task automatic test_random(int n_items);
		int sent, cx, cz, span, ybase, n;
		sent = 0;
		while (sent < n_items) begin
			send_burst = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) == 0) begin
				send_clear();
				sent++;
			end
			if ($urandom_range(0, 19) == 0) begin
				req_ch.valid <= 1'b0;
				while (pending_heights.size() != 0) @(posedge clk);
			end
			cx    = $urandom_range(0, 1 << 25) - (1 << 24);
			cz    = $urandom_range(0, 1 << 25) - (1 << 24);
			span  = $urandom_range(ONE / 4, 8 * ONE);
			ybase = $urandom_range(0, 1 << 26) - (1 << 25);
			n = $urandom_range(1, 10);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 9) == 0) send_load(noise_tri());
				else send_load(near_tri(cx, cz, span, ybase, $urandom_range(0, 4 * ONE)));
				sent++;
			end
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 9) == 0) send_query($urandom, $urandom);
				else send_query(cx + $urandom_range(0, 2 * span) - span,
					cz + $urandom_range(0, 2 * span) - span);
				sent++;
			end
			if ($urandom_range(0, 14) == 0) send_req(2'd3, noise_tri(), $urandom, $urandom);
		end
	endtask

	// run limit
	initial begin
		#60ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
		req_ch.valid <= 1'b0; req_ch.op <= OP_CLEAR;
		req_ch.vx0 <= '0; req_ch.vy0 <= '0; req_ch.vz0 <= '0;
		req_ch.vx1 <= '0; req_ch.vy1 <= '0; req_ch.vz1 <= '0;
		req_ch.vx2 <= '0; req_ch.vy2 <= '0; req_ch.vz2 <= '0;
		req_ch.query_x <= '0; req_ch.query_z <= '0;
		tri_cnt = 0; ovf_flag = 1'b0;
		cfg.start_height = START_RST;
		cfg.max_dist     = MAXDIST_RST;
		cfg.det_thr      = DETTHR_RST;
		error_count = 0; checked_count = 0; hit_count = 0;
		load_count = 0; query_count = 0;
		send_burst = 1'b0; rsp_burst = 1'b0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_config_sweep();
		test_overflow();
		test_random(430);
		drain();

		$display("covered %0d loads and %0d queries (%0d hits) over four register settings",
			load_count, query_count, hit_count);
		$display("table overflow, clears, degenerate and extreme triangles included; %0d errors",
			error_count);
		if (error_count == 0 && pending_heights.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
